>>> hw/rtl/pptyc_pkg.sv
// shared types and constants for the palette pair to ycbcr 4:2:2 converter
// no dependencies; used by every module of the block

package pptyc_pkg;

   // request kinds
   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_PAIR  = 1'b1
   } cmd_type;

   // palette entry layout: red in 23..16, green in 15..8, blue in 7..0
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // load enables for the two conversion stages
   typedef struct packed {
      logic num_en;
      logic quo_en;
   } stage_en_type;

   // bt.601 full range luma weights, scaled by 1000
   localparam logic [8:0] Y_COEF_R = 9'd299;
   localparam logic [9:0] Y_COEF_G = 10'd587;
   localparam logic [6:0] Y_COEF_B = 7'd114;

   // chroma weights, scaled by 100000 (signs applied in the datapath)
   localparam logic [14:0] CB_COEF_R = 15'd16874;
   localparam logic [15:0] CB_COEF_G = 16'd33126;
   localparam logic [15:0] CHROMA_HALF = 16'd50000;
   localparam logic [15:0] CR_COEF_G = 16'd41869;
   localparam logic [12:0] CR_COEF_B = 13'd8131;
   localparam logic [23:0] CHROMA_OFS = 24'd12800000;

   // numerator widths: luma peaks at 255000, chroma at 25550000
   localparam int YNUM_W = 18;
   localparam int CNUM_W = 25;

   // ceiling reciprocals; exact for the numerator ranges above
   localparam int          Y_SHIFT = 28;
   localparam logic [18:0] Y_RECIP = 19'd268436;
   localparam int          C_SHIFT = 41;
   localparam logic [24:0] C_RECIP = 25'd21990233;

   localparam int YPROD_W = YNUM_W + 19;
   localparam int CPROD_W = CNUM_W + 25;

endpackage

>>> hw/rtl/pptyc_palette_ram.sv
// palette store: one write port and two registered read ports
// depends on pptyc_pkg for the entry type

module pptyc_palette_ram #(
   parameter int  PALETTE_ENTRIES = 256,
   localparam int ADDR_W = $clog2(PALETTE_ENTRIES)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pptyc_pkg::rgb_type  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr_a,
   input  logic [ADDR_W-1:0]   rd_addr_b,
   output pptyc_pkg::rgb_type  rd_data_a,
   output pptyc_pkg::rgb_type  rd_data_b
);

   pptyc_pkg::rgb_type store_ff [PALETTE_ENTRIES];
   pptyc_pkg::rgb_type rd_a_ff;
   pptyc_pkg::rgb_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> hw/rtl/pptyc_color_pipe.sv
// two-stage rgb to y/cb/cr conversion for one pixel
// depends on pptyc_pkg for coefficients, reciprocals and types

module pptyc_color_pipe (
   input  logic                    clock,
   input  pptyc_pkg::stage_en_type en,
   input  pptyc_pkg::rgb_type      pixel,
   output logic [7:0]              luma,
   output logic [7:0]              cb,
   output logic [7:0]              cr
);

   logic [pptyc_pkg::YNUM_W-1:0]  y_num_in,  y_num_ff;
   logic [pptyc_pkg::CNUM_W-1:0]  cb_num_in, cb_num_ff;
   logic [pptyc_pkg::CNUM_W-1:0]  cr_num_in, cr_num_ff;
   logic [pptyc_pkg::YPROD_W-1:0] y_prod;
   logic [pptyc_pkg::CPROD_W-1:0] cb_prod;
   logic [pptyc_pkg::CPROD_W-1:0] cr_prod;
   logic [7:0]                    luma_ff, cb_ff, cr_ff;

   // numerators; chroma is taken modulo 2^25, the true value never leaves range
   always_comb begin
      y_num_in  = pptyc_pkg::YNUM_W'(pixel.red)   * pptyc_pkg::YNUM_W'(pptyc_pkg::Y_COEF_R)
                + pptyc_pkg::YNUM_W'(pixel.green) * pptyc_pkg::YNUM_W'(pptyc_pkg::Y_COEF_G)
                + pptyc_pkg::YNUM_W'(pixel.blue)  * pptyc_pkg::YNUM_W'(pptyc_pkg::Y_COEF_B);
      cb_num_in = pptyc_pkg::CNUM_W'(pixel.blue)  * pptyc_pkg::CNUM_W'(pptyc_pkg::CHROMA_HALF)
                + pptyc_pkg::CNUM_W'(pptyc_pkg::CHROMA_OFS)
                - pptyc_pkg::CNUM_W'(pixel.red)   * pptyc_pkg::CNUM_W'(pptyc_pkg::CB_COEF_R)
                - pptyc_pkg::CNUM_W'(pixel.green) * pptyc_pkg::CNUM_W'(pptyc_pkg::CB_COEF_G);
      cr_num_in = pptyc_pkg::CNUM_W'(pixel.red)   * pptyc_pkg::CNUM_W'(pptyc_pkg::CHROMA_HALF)
                + pptyc_pkg::CNUM_W'(pptyc_pkg::CHROMA_OFS)
                - pptyc_pkg::CNUM_W'(pixel.green) * pptyc_pkg::CNUM_W'(pptyc_pkg::CR_COEF_G)
                - pptyc_pkg::CNUM_W'(pixel.blue)  * pptyc_pkg::CNUM_W'(pptyc_pkg::CR_COEF_B);
   end

   always_ff @(posedge clock) begin
      if (en.num_en) begin
         y_num_ff  <= y_num_in;
         cb_num_ff <= cb_num_in;
         cr_num_ff <= cr_num_in;
      end
   end

   // truncating divide as multiply by ceiling reciprocal and shift
   always_comb begin
      y_prod  = pptyc_pkg::YPROD_W'(y_num_ff)  * pptyc_pkg::YPROD_W'(pptyc_pkg::Y_RECIP);
      cb_prod = pptyc_pkg::CPROD_W'(cb_num_ff) * pptyc_pkg::CPROD_W'(pptyc_pkg::C_RECIP);
      cr_prod = pptyc_pkg::CPROD_W'(cr_num_ff) * pptyc_pkg::CPROD_W'(pptyc_pkg::C_RECIP);
   end

   always_ff @(posedge clock) begin
      if (en.quo_en) begin
         luma_ff <= y_prod[pptyc_pkg::Y_SHIFT +: 8];
         cb_ff   <= cb_prod[pptyc_pkg::C_SHIFT +: 8];
         cr_ff   <= cr_prod[pptyc_pkg::C_SHIFT +: 8];
      end
   end

   assign luma = luma_ff;
   assign cb   = cb_ff;
   assign cr   = cr_ff;

endmodule

>>> hw/rtl/palette_pair_to_ycbcr422.sv
// palette pair to ycbcr 4:2:2: top level with palette memory and pipeline control
// depends on pptyc_pkg, pptyc_palette_ram and pptyc_color_pipe
//
// usage
//   request channel (req_valid / req_stall): a request is taken at a clock edge
//   with req_valid high and req_stall low. req_command selects a palette write
//   (index plus red, green, blue) or a pixel pair (two palette indices).
//   palette writes give no response. each pixel pair gives one response word
//   luma_first, chroma_blue, luma_second, chroma_red on the rsp_ channel,
//   taken when rsp_valid is high and rsp_stall is low.
//   a pair request passes the four registered stages (memory read, numerators,
//   reciprocal multiply, chroma average / output) before its response is valid.
//   throughput: one request per clock while req_stall is low, set by the single
//   palette write port and the two read ports that serve both pixels of a pair at once.
//   a palette write is visible to any pair request taken on a later edge.
//   reset (synchronous, active high) empties the pipeline; the palette
//   contents are not cleared and must be written before they are used.
//   when the receiver stalls, the pipeline keeps taking requests until its
//   four stages are full, then raises req_stall.

module palette_pair_to_ycbcr422 #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_palette_index,
   input  logic [7:0] req_palette_red,
   input  logic [7:0] req_palette_green,
   input  logic [7:0] req_palette_blue,
   input  logic [7:0] req_left_pixel,
   input  logic [7:0] req_right_pixel,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_luma_first,
   output logic [7:0] rsp_chroma_blue,
   output logic [7:0] rsp_luma_second,
   output logic [7:0] rsp_chroma_red
);

   localparam int         ADDR_W      = $clog2(PALETTE_ENTRIES);
   localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

   // stage valid bits: s1 read data, s2 numerators, s3 quotients, s4 output
   logic s1_valid_in, s1_valid_ff;
   logic s2_valid_in, s2_valid_ff;
   logic s3_valid_in, s3_valid_ff;
   logic s4_valid_in, s4_valid_ff;

   // each stage moves when it is empty or the next one moves
   logic rdy1, rdy2, rdy3, rdy4;
   logic accept;
   logic is_pair;
   logic wr_en;

   // indices beyond the palette read as black
   logic left_oob_in, left_oob_ff;
   logic right_oob_in, right_oob_ff;

   pptyc_pkg::rgb_type wr_data;
   pptyc_pkg::rgb_type rd_left, rd_right;
   pptyc_pkg::rgb_type pix_left, pix_right;

   pptyc_pkg::stage_en_type pipe_en;

   logic [7:0] luma_l, cb_l, cr_l;
   logic [7:0] luma_r, cb_r, cr_r;
   logic [8:0] cb_sum, cr_sum;

   logic [7:0] luma_first_ff, chroma_blue_ff, luma_second_ff, chroma_red_ff;

   // back-pressure chain from the output register toward the request side
   always_comb begin
      rdy4 = !s4_valid_ff || !rsp_stall;
      rdy3 = !s3_valid_ff || rdy4;
      rdy2 = !s2_valid_ff || rdy3;
      rdy1 = !s1_valid_ff || rdy2;
   end

   assign req_stall = !rdy1;
   assign accept    = req_valid && rdy1;
   assign is_pair   = (req_command == pptyc_pkg::CMD_PAIR);

   // palette write commits at the accept edge, so later pairs read it directly
   assign wr_en   = accept && !is_pair && ({1'b0, req_palette_index} < ENTRY_LIMIT);
   assign wr_data = '{red: req_palette_red, green: req_palette_green,
                      blue: req_palette_blue};

   assign left_oob_in  = !({1'b0, req_left_pixel}  < ENTRY_LIMIT);
   assign right_oob_in = !({1'b0, req_right_pixel} < ENTRY_LIMIT);

   pptyc_palette_ram #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (req_palette_index[ADDR_W-1:0]),
      .wr_data   (wr_data),
      .rd_en     (rdy1),
      .rd_addr_a (req_left_pixel[ADDR_W-1:0]),
      .rd_addr_b (req_right_pixel[ADDR_W-1:0]),
      .rd_data_a (rd_left),
      .rd_data_b (rd_right)
   );

   always_ff @(posedge clock) begin
      if (rdy1) begin
         left_oob_ff  <= left_oob_in;
         right_oob_ff <= right_oob_in;
      end
   end

   assign pix_left  = left_oob_ff  ? '0 : rd_left;
   assign pix_right = right_oob_ff ? '0 : rd_right;

   assign pipe_en = '{num_en: rdy2, quo_en: rdy3};

   pptyc_color_pipe u_pipe_left (
      .clock (clock),
      .en    (pipe_en),
      .pixel (pix_left),
      .luma  (luma_l),
      .cb    (cb_l),
      .cr    (cr_l)
   );

   pptyc_color_pipe u_pipe_right (
      .clock (clock),
      .en    (pipe_en),
      .pixel (pix_right),
      .luma  (luma_r),
      .cb    (cb_r),
      .cr    (cr_r)
   );

   // stage valids; only pair requests enter the pipeline
   always_comb begin
      s1_valid_in = rdy1 ? (accept && is_pair) : s1_valid_ff;
      s2_valid_in = rdy2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = rdy3 ? s2_valid_ff : s3_valid_ff;
      s4_valid_in = rdy4 ? s3_valid_ff : s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // chroma of the pair averaged by a right shift
   assign cb_sum = {1'b0, cb_l} + {1'b0, cb_r};
   assign cr_sum = {1'b0, cr_l} + {1'b0, cr_r};

   // output register
   always_ff @(posedge clock) begin
      if (rdy4) begin
         luma_first_ff  <= luma_l;
         chroma_blue_ff <= cb_sum[8:1];
         luma_second_ff <= luma_r;
         chroma_red_ff  <= cr_sum[8:1];
      end
   end

   assign rsp_valid       = s4_valid_ff;
   assign rsp_luma_first  = luma_first_ff;
   assign rsp_chroma_blue = chroma_blue_ff;
   assign rsp_luma_second = luma_second_ff;
   assign rsp_chroma_red  = chroma_red_ff;

`ifndef SYNTHESIS
   // requests are held off only when every stage is occupied
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff))
      else $error("request stalled with a bubble in the pipeline");

   // a taken pair always lands in the read stage
   a_pair_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && is_pair) |=> s1_valid_ff)
      else $error("accepted pixel pair lost before read stage");

   // a palette write never produces a response
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_pair) |=> !s1_valid_ff)
      else $error("palette write entered the conversion pipeline");

   // a blocked output keeps the quotient stage from moving on
   a_hold_on_block: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && rsp_stall && s3_valid_ff) |=> (s3_valid_ff && s4_valid_ff))
      else $error("pipeline advanced into a stalled output");
`endif

endmodule

>>> tb/sv/pptyc_ycbcr_checker.sv
// response checker for palette_pair_to_ycbcr422: tracks the palette, predicts each word
// depends on pptyc_pkg; instantiated beside the block by palette_pair_to_ycbcr422_tb

`timescale 1ns / 1ps

module pptyc_ycbcr_checker #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_palette_index,
   input  logic [7:0] req_palette_red,
   input  logic [7:0] req_palette_green,
   input  logic [7:0] req_palette_blue,
   input  logic [7:0] req_left_pixel,
   input  logic [7:0] req_right_pixel,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_luma_first,
   input  logic [7:0] rsp_chroma_blue,
   input  logic [7:0] rsp_luma_second,
   input  logic [7:0] rsp_chroma_red,
   output int         mismatch_count,
   output int         words_pending,
   output int         words_checked
);

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
   } ycbcr_word_type;

   pptyc_pkg::rgb_type palette_copy [PALETTE_ENTRIES];
   ycbcr_word_type     expected_words [$];

   int fail_tally    = 0;
   int queued_words  = 0;
   int checked_words = 0;

   assign mismatch_count = fail_tally;
   assign words_pending  = queued_words;
   assign words_checked  = checked_words;

   // indexes past the palette read as black
   function automatic pptyc_pkg::rgb_type lookup_color(input logic [7:0] idx);
      if (int'(idx) >= PALETTE_ENTRIES) return '0;
      return palette_copy[idx];
   endfunction

   function automatic int pixel_luma(input pptyc_pkg::rgb_type c);
      int red, green, blue;
      red = c.red;
      green = c.green;
      blue = c.blue;
      return (299 * red + 587 * green + 114 * blue) / 1000;
   endfunction

   function automatic int pixel_cb(input pptyc_pkg::rgb_type c);
      int red, green, blue;
      red = c.red;
      green = c.green;
      blue = c.blue;
      return (50000 * blue + 12800000 - 16874 * red - 33126 * green) / 100000;
   endfunction

   function automatic int pixel_cr(input pptyc_pkg::rgb_type c);
      int red, green, blue;
      red = c.red;
      green = c.green;
      blue = c.blue;
      return (50000 * red + 12800000 - 41869 * green - 8131 * blue) / 100000;
   endfunction

   function automatic ycbcr_word_type convert_pair(input pptyc_pkg::rgb_type first,
                                                   input pptyc_pkg::rgb_type second);
      ycbcr_word_type w;
      w.luma_first  = 8'(pixel_luma(first));
      w.chroma_blue = 8'((pixel_cb(first) + pixel_cb(second)) >> 1);
      w.luma_second = 8'(pixel_luma(second));
      w.chroma_red  = 8'((pixel_cr(first) + pixel_cr(second)) >> 1);
      return w;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin : monitor
      ycbcr_word_type want;
      if (reset) begin
         expected_words.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_command == pptyc_pkg::CMD_PAIR) begin
               expected_words.push_back(convert_pair(lookup_color(req_left_pixel),
                                                     lookup_color(req_right_pixel)));
            end else if (int'(req_palette_index) < PALETTE_ENTRIES) begin
               palette_copy[req_palette_index] = {req_palette_red, req_palette_green,
                                                  req_palette_blue};
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("response with no pair outstanding: %0d %0d %0d %0d", rsp_luma_first,
                      rsp_chroma_blue, rsp_luma_second, rsp_chroma_red);
               fail_tally++;
            end else begin
               want = expected_words.pop_front();
               check_field("luma_first", want.luma_first, rsp_luma_first);
               check_field("chroma_blue", want.chroma_blue, rsp_chroma_blue);
               check_field("luma_second", want.luma_second, rsp_luma_second);
               check_field("chroma_red", want.chroma_red, rsp_chroma_red);
               checked_words++;
            end
         end
      end
      queued_words = expected_words.size();
   end

endmodule

>>> tb/sv/palette_pair_to_ycbcr422_tb.sv
// top of the palette_pair_to_ycbcr422 testbench: clock, reset, request and stall traffic
// depends on pptyc_pkg, palette_pair_to_ycbcr422 and pptyc_ycbcr_checker

`timescale 1ns / 1ps

module palette_pair_to_ycbcr422_tb;

   localparam int RANDOM_REQUESTS = 1880;
   localparam int QUIET_TAIL      = 300;   // last requests run with no idling at all
   localparam int HOLD_START      = 500;   // random request at which the long hold-off begins
   localparam int HOLD_CYCLES     = 150;
   localparam int STALL_LIMIT     = 2000;  // cycles with no transfer before giving up
   localparam int DRAIN_CYCLES    = 16;    // four stage pipeline plus margin

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   pptyc_pkg::cmd_type req_command = pptyc_pkg::CMD_WRITE;
   logic [7:0] req_palette_index = '0;
   logic [7:0] req_palette_red = '0;
   logic [7:0] req_palette_green = '0;
   logic [7:0] req_palette_blue = '0;
   logic [7:0] req_left_pixel = '0;
   logic [7:0] req_right_pixel = '0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_luma_first;
   logic [7:0] rsp_chroma_blue;
   logic [7:0] rsp_luma_second;
   logic [7:0] rsp_chroma_red;

   int mismatches;
   int words_pending;
   int words_checked;

   // shared between the request process and the receiver process
   bit idling_on      = 1'b0;
   bit want_hold      = 1'b0;
   bit hold_active    = 1'b0;
   bit saw_backpressure = 1'b0;

   // stimulus bookkeeping: only written entries may be read by a pair
   bit               entry_written [256];
   logic [7:0]       written_list [$];
   int               writes_sent = 0;
   int               pairs_sent = 0;
   int               stalled_cycles = 0;

   palette_pair_to_ycbcr422 u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_palette_index (req_palette_index),
      .req_palette_red   (req_palette_red),
      .req_palette_green (req_palette_green),
      .req_palette_blue  (req_palette_blue),
      .req_left_pixel    (req_left_pixel),
      .req_right_pixel   (req_right_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_luma_first    (rsp_luma_first),
      .rsp_chroma_blue   (rsp_chroma_blue),
      .rsp_luma_second   (rsp_luma_second),
      .rsp_chroma_red    (rsp_chroma_red)
   );

   pptyc_ycbcr_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_palette_index (req_palette_index),
      .req_palette_red   (req_palette_red),
      .req_palette_green (req_palette_green),
      .req_palette_blue  (req_palette_blue),
      .req_left_pixel    (req_left_pixel),
      .req_right_pixel   (req_right_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_luma_first    (rsp_luma_first),
      .rsp_chroma_blue   (rsp_chroma_blue),
      .rsp_luma_second   (rsp_luma_second),
      .rsp_chroma_red    (rsp_chroma_red),
      .mismatch_count    (mismatches),
      .words_pending     (words_pending),
      .words_checked     (words_checked)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: count cycles in which neither channel moves anything
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      // the hold-off is meant to back the pipeline up into the request side
      if (hold_active && req_valid && req_stall) begin
         saw_backpressure <= 1'b1;
      end
   end

   initial begin
      wait (stalled_cycles >= STALL_LIMIT);
      $error("no transfer for %0d cycles, %0d words still outstanding", STALL_LIMIT,
             words_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off on request, quiet at the end
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (want_hold) begin
            want_hold = 1'b0;
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_active = 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one request and hold it until taken; valid stays high when no gap follows
   task automatic send_request(input pptyc_pkg::cmd_type cmd, input logic [7:0] idx,
                               input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue, input logic [7:0] left_idx,
                               input logic [7:0] right_idx);
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_palette_index <= idx;
      req_palette_red   <= red;
      req_palette_green <= green;
      req_palette_blue  <= blue;
      req_left_pixel    <= left_idx;
      req_right_pixel   <= right_idx;
      do @(posedge clock); while (req_stall);
      // sender keeps offering while the receiver is held off
      if (idling_on && !hold_active && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // pixel fields are unused by a palette write, so they carry noise
   task automatic write_entry(input logic [7:0] idx, input logic [7:0] red,
                              input logic [7:0] green, input logic [7:0] blue);
      send_request(pptyc_pkg::CMD_WRITE, idx, red, green, blue, 8'($urandom), 8'($urandom));
      writes_sent++;
      if (!entry_written[idx]) begin
         entry_written[idx] = 1'b1;
         written_list.push_back(idx);
      end
   endtask

   // palette fields are unused by a pair, so they carry noise
   task automatic send_pair(input logic [7:0] left_idx, input logic [7:0] right_idx);
      send_request(pptyc_pkg::CMD_PAIR, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), left_idx, right_idx);
      pairs_sent++;
   endtask

   // color component with extra weight on the rails
   function automatic logic [7:0] color_level();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'd0;
      if (pick == 1) return 8'd255;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_written();
      return written_list[$urandom_range(0, written_list.size() - 1)];
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: black, white, primaries and the chroma rails, back to back
      write_entry(8'd0, 8'd0, 8'd0, 8'd0);
      write_entry(8'd255, 8'd255, 8'd255, 8'd255);
      write_entry(8'd1, 8'd255, 8'd0, 8'd0);      // red: cr at its top
      write_entry(8'd2, 8'd0, 8'd255, 8'd0);
      write_entry(8'd3, 8'd0, 8'd0, 8'd255);      // blue: cb at its top
      write_entry(8'd4, 8'd255, 8'd255, 8'd0);    // yellow: cb at its bottom
      write_entry(8'd5, 8'd0, 8'd255, 8'd255);    // cyan: cr at its bottom
      write_entry(8'd128, 8'd128, 8'd128, 8'd128);
      send_pair(8'd0, 8'd255);
      send_pair(8'd255, 8'd0);
      send_pair(8'd1, 8'd5);
      send_pair(8'd3, 8'd4);
      send_pair(8'd2, 8'd3);
      send_pair(8'd255, 8'd255);
      send_pair(8'd0, 8'd0);
      send_pair(8'd128, 8'd1);
      // overwrite followed at once by a read of the same entry
      write_entry(8'd1, 8'd0, 8'd0, 8'd255);
      send_pair(8'd1, 8'd4);
      send_pair(8'd5, 8'd1);

      // random: a third palette writes, the rest pairs over written entries
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         idling_on = (n < RANDOM_REQUESTS - QUIET_TAIL) && ((n / 200) % 3 != 2);
         if (n == HOLD_START) want_hold = 1'b1;
         if ($urandom_range(0, 99) < 35) begin
            write_entry(8'($urandom), color_level(), color_level(), color_level());
         end else begin
            send_pair(pick_written(), pick_written());
         end
      end
      req_valid <= 1'b0;

      // wait for every predicted word, then let the pipeline run dry
      while (words_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d palette writes over %0d entries and %0d pixel pairs",
               writes_sent, written_list.size(), pairs_sent);
      $display("%0d response words compared, request side back-pressured during hold-off: %0d",
               words_checked, saw_backpressure);
      if (mismatches == 0 && words_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/pptyc_pkg.sv
hw/rtl/pptyc_palette_ram.sv
hw/rtl/pptyc_color_pipe.sv
hw/rtl/palette_pair_to_ycbcr422.sv
tb/sv/pptyc_ycbcr_checker.sv
tb/sv/palette_pair_to_ycbcr422_tb.sv
